// ===== design/ldfp_pkg.sv =====
// ---------------------------------------------------------------------------
// Labeled decimal field parser package
// Shared widths, character codes, state encodings and the result record.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ldfp_pkg;

  localparam int FRAC_DIGITS = 3;
  localparam int VALUE_BITS  = 32;
  localparam int MAG_BITS    = VALUE_BITS - 1;
  localparam int CH_BITS     = 8;
  localparam int CFG_IDX_W   = 1;
  localparam int FRAC_CNT_W  = 3;
  localparam int SCALE_BITS  = $clog2(10 ** FRAC_DIGITS + 1);
  localparam int PROD_BITS   = MAG_BITS + SCALE_BITS;
  localparam int ACC_BITS    = MAG_BITS + 4;
  localparam int OUT_TDATA_W = ((VALUE_BITS + 7) / 8) * 8;
  localparam int OUT_TUSER_W = 2;

  localparam logic [MAG_BITS-1:0] MAG_MAX = '1;

  localparam logic [CH_BITS-1:0] CH_MINUS = 8'h2d;
  localparam logic [CH_BITS-1:0] CH_PLUS  = 8'h2b;
  localparam logic [CH_BITS-1:0] CH_SEMI  = 8'h3b;
  localparam logic [CH_BITS-1:0] CH_NL    = 8'h0a;
  localparam logic [CH_BITS-1:0] CH_DOT   = 8'h2e;
  localparam logic [CH_BITS-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_BITS-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_BITS-1:0] CH_NINE  = 8'h39;

  localparam logic [CH_BITS-1:0] LABEL_FIRST_RST  = 8'd86;
  localparam logic [CH_BITS-1:0] LABEL_SECOND_RST = 8'd58;

  typedef enum logic [3:0] {
    PH_SEARCH = 4'b0001,
    PH_SIGN   = 4'b0010,
    PH_DIGITS = 4'b0100,
    PH_STOP   = 4'b1000
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LABEL_FIRST  = 1'b0,
    REG_LABEL_SECOND = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic                  found;
    logic                  saturated;
  } result_t;

  // Scale factor that pads the missing fraction digits with zeros.
  function automatic logic [SCALE_BITS-1:0] pow10(input logic [FRAC_CNT_W-1:0] n);
    logic [SCALE_BITS-1:0] p;
    p = SCALE_BITS'(1);
    for (int i = 0; i < FRAC_DIGITS; i++) begin
      if (i < int'(n)) begin
        p = SCALE_BITS'(p * SCALE_BITS'(10));
      end
    end
    return p;
  endfunction

endpackage

`default_nettype wire

// ===== design/labeled_decimal_field_parser.sv =====
// ---------------------------------------------------------------------------
// Labeled decimal field parser
// Finds a two-character label in a text line and converts the decimal
// number after it into a saturated signed fixed-point value.
// ---------------------------------------------------------------------------
// The block takes one character per clock cycle on the input stream while
// in_tready is high; a transaction with in_tlast high marks the end of the
// line and produces exactly one result transaction, holding the value in
// units of 10^-3, a found flag and a saturation flag. The per-character step
// is a compare and a multiply-by-ten accumulate into the line state
// registers, and the end-of-line step is one multiply by a power of ten that
// pads the fraction, so the block sustains that rate. An output register
// with a skid stage lets input keep flowing while a result waits.
`timescale 1ns / 1ps
`default_nettype none

module labeled_decimal_field_parser (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [ldfp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ldfp_pkg::CH_BITS-1:0]        cfg_wdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [ldfp_pkg::CH_BITS-1:0]        in_tdata,   // ch
  input  logic                                in_tlast,   // line_end
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [ldfp_pkg::OUT_TDATA_W-1:0]    out_tdata,  // value
  output logic [ldfp_pkg::OUT_TUSER_W-1:0]    out_tuser   // found, saturated
);
  import ldfp_pkg::*;

  logic [CH_BITS-1:0]    label_first_r;
  logic [CH_BITS-1:0]    label_second_r;

  phase_t                phase_r, phase_nxt;
  logic                  prev_r, prev_nxt;
  logic [MAG_BITS-1:0]   mag_r, mag_nxt;
  logic                  neg_r, neg_nxt;
  logic                  pt_r, pt_nxt;
  logic [FRAC_CNT_W-1:0] fcnt_r, fcnt_nxt;
  logic                  ovf_r, ovf_nxt;

  result_t               main_r, main_nxt;
  logic                  main_v_r, main_v_nxt;
  result_t               skid_r, skid_nxt;
  logic                  skid_v_r, skid_v_nxt;

  logic                  accept;
  logic                  digit_mode;
  logic                  is_digit;
  logic                  push;
  logic [3:0]            digit;
  logic [ACC_BITS-1:0]   acc;

  logic [FRAC_CNT_W-1:0] pad_n;
  logic [PROD_BITS-1:0]  prod;
  logic                  sat;
  logic [MAG_BITS-1:0]   mag_final;
  logic [VALUE_BITS-1:0] mag_ext;
  result_t               res;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = !skid_v_r;

  assign out_tvalid = main_v_r;
  assign out_tdata  = OUT_TDATA_W'(main_r.value);
  assign out_tuser  = {main_r.saturated, main_r.found};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      label_first_r  <= LABEL_FIRST_RST;
      label_second_r <= LABEL_SECOND_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_LABEL_FIRST:  label_first_r  <= cfg_wdata;
        REG_LABEL_SECOND: label_second_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign is_digit = in_tdata inside {[CH_ZERO:CH_NINE]};
  assign digit    = 4'(in_tdata - CH_ZERO);
  assign acc      = (ACC_BITS'(mag_r) << 3) + (ACC_BITS'(mag_r) << 1) + ACC_BITS'(digit);

  always_comb begin
    phase_nxt  = phase_r;
    prev_nxt   = prev_r;
    mag_nxt    = mag_r;
    neg_nxt    = neg_r;
    pt_nxt     = pt_r;
    fcnt_nxt   = fcnt_r;
    ovf_nxt    = ovf_r;
    digit_mode = 1'b0;
    push       = 1'b0;

    case (phase_r)
      PH_SEARCH: begin
        if (prev_r && in_tdata == label_second_r) begin
          phase_nxt = PH_SIGN;
          prev_nxt  = 1'b0;
        end else begin
          prev_nxt = (in_tdata == label_first_r);
        end
      end
      PH_SIGN: begin
        if (in_tdata != CH_SPACE) begin
          phase_nxt = PH_DIGITS;
          if (in_tdata == CH_MINUS) begin
            neg_nxt = 1'b1;
          end else if (in_tdata != CH_PLUS) begin
            digit_mode = 1'b1;
          end
        end
      end
      PH_DIGITS: begin
        digit_mode = 1'b1;
      end
      default: ;
    endcase

    if (digit_mode) begin
      if (in_tdata == CH_SEMI || in_tdata == CH_NL) begin
        phase_nxt = PH_STOP;
      end else if (in_tdata == CH_DOT) begin
        pt_nxt = 1'b1;
      end else if (is_digit) begin
        if (!pt_r) begin
          push = 1'b1;
        end else if (fcnt_r < FRAC_CNT_W'(FRAC_DIGITS)) begin
          push     = 1'b1;
          fcnt_nxt = fcnt_r + 1'b1;
        end
      end else begin
        phase_nxt = PH_STOP;
      end
    end

    if (push && !ovf_r) begin
      if (acc > ACC_BITS'(MAG_MAX)) begin
        mag_nxt = MAG_MAX;
        ovf_nxt = 1'b1;
      end else begin
        mag_nxt = acc[MAG_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SEARCH;
      prev_r  <= 1'b0;
      mag_r   <= '0;
      neg_r   <= 1'b0;
      pt_r    <= 1'b0;
      fcnt_r  <= '0;
      ovf_r   <= 1'b0;
    end else if (accept) begin
      if (in_tlast) begin
        phase_r <= PH_SEARCH;
        prev_r  <= 1'b0;
        mag_r   <= '0;
        neg_r   <= 1'b0;
        pt_r    <= 1'b0;
        fcnt_r  <= '0;
        ovf_r   <= 1'b0;
      end else begin
        phase_r <= phase_nxt;
        prev_r  <= prev_nxt;
        mag_r   <= mag_nxt;
        neg_r   <= neg_nxt;
        pt_r    <= pt_nxt;
        fcnt_r  <= fcnt_nxt;
        ovf_r   <= ovf_nxt;
      end
    end
  end

  // The fraction is padded in one step: scaling by 10^n overflows exactly
  // when the digit-by-digit padding would have clamped.
  assign pad_n     = FRAC_CNT_W'(FRAC_DIGITS) - fcnt_r;
  assign prod      = PROD_BITS'(mag_r) * PROD_BITS'(pow10(pad_n));
  assign sat       = ovf_r || (prod > PROD_BITS'(MAG_MAX));
  assign mag_final = sat ? MAG_MAX : prod[MAG_BITS-1:0];
  assign mag_ext   = VALUE_BITS'(mag_final);

  always_comb begin
    if (phase_r == PH_SEARCH) begin
      res.value     = '0;
      res.found     = 1'b0;
      res.saturated = 1'b0;
    end else begin
      res.value     = neg_r ? (~mag_ext + 1'b1) : mag_ext;
      res.found     = 1'b1;
      res.saturated = sat;
    end
  end

  always_comb begin
    main_nxt   = main_r;
    main_v_nxt = main_v_r;
    skid_nxt   = skid_r;
    skid_v_nxt = skid_v_r;
    if (main_v_r && !out_tready) begin
      if (accept && in_tlast) begin
        skid_nxt   = res;
        skid_v_nxt = 1'b1;
      end
    end else if (skid_v_r) begin
      main_nxt   = skid_r;
      main_v_nxt = 1'b1;
      skid_v_nxt = 1'b0;
    end else begin
      main_nxt   = res;
      main_v_nxt = accept && in_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      main_v_r <= main_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule

`default_nettype wire

// ===== design/ldfp_checker.sv =====
// ---------------------------------------------------------------------------
// Labeled decimal field parser checker
// Port-level properties of the parser, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ldfp_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_tvalid,
  input logic                                in_tready,
  input logic                                in_tlast,   // line_end
  input logic                                out_tvalid,
  input logic                                out_tready,
  input logic [ldfp_pkg::OUT_TDATA_W-1:0]    out_tdata,  // value
  input logic [ldfp_pkg::OUT_TUSER_W-1:0]    out_tuser   // found, saturated
);
  import ldfp_pkg::*;

  localparam logic [VALUE_BITS-1:0] POS_LIMIT = {1'b0, MAG_MAX};
  localparam logic [VALUE_BITS-1:0] NEG_LIMIT = ~{1'b0, MAG_MAX} + 1'b1;
  localparam logic [VALUE_BITS-1:0] MOST_NEG  = {1'b1, {MAG_BITS{1'b0}}};

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[VALUE_BITS-1:0] == '0 && !out_tuser[1])
    else $error("missing label must give a zero value and no saturation");

  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |->
      out_tdata[VALUE_BITS-1:0] == POS_LIMIT || out_tdata[VALUE_BITS-1:0] == NEG_LIMIT)
    else $error("saturated result is not at the range limit");

  a_no_most_neg: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[VALUE_BITS-1:0] != MOST_NEG)
    else $error("result outside the symmetric range");

  a_result_needs_line_end: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid && !(in_tvalid && in_tready && in_tlast) |=> !out_tvalid)
    else $error("result appeared without an end-of-line transaction");

endmodule

bind labeled_decimal_field_parser ldfp_checker u_ldfp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
